// File: hdl/poi_pkg.sv
`default_nettype none
package poi_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int CNT_W = 6;
  localparam int DIV_STEPS = 18;
  localparam int IN_W = 160;
  localparam int OUT_W = 288;
  localparam int RATIO_W = 24;
  localparam int POS_W = 48;
  localparam int DVD_W = 72;

  localparam logic [RATIO_W-1:0] RATIO_RST = 24'd65536;
  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
  localparam logic [13:0] DIV_K = 14'd15625;
  localparam logic [95:0] HALF_YAW = 96'd15625 << 21;
  localparam logic [95:0] HALF_POS = 96'd15625 << 27;
  localparam logic signed [33:0] COR_X0 = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

  typedef enum logic [1:0] {
    SEL_YAW = 2'd0,
    SEL_X   = 2'd1,
    SEL_Y   = 2'd2
  } poi_sel_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_MDT   = 11'b00000000010,
    ST_MLO   = 11'b00000000100,
    ST_MHI   = 11'b00000001000,
    ST_DLOAD = 11'b00000010000,
    ST_DIV   = 11'b00000100000,
    ST_UPD   = 11'b00001000000,
    ST_CLOAD = 11'b00010000000,
    ST_CSTEP = 11'b00100000000,
    ST_CDONE = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } poi_state_t;

  typedef struct packed {
    logic       load;
    logic       mul_dt;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_load;
    logic       div_step;
    logic       upd;
    logic       cor_load;
    logic       cor_step;
    logic       cor_done;
    logic       half;
    logic       out_load;
    poi_sel_t   sel;
    logic [4:0] idx;
  } poi_cmd_t;

  typedef struct packed {
    logic out_free;
  } poi_stat_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/planar_odometry_integrator_core.sv
// Channel   Ports                          Word
// in        in_tvalid/in_tready/in_tdata    one velocity report
// out       out_tvalid/out_tready/out_tdata one pose result
// cfg       cfg_tvalid/cfg_tready/cfg_tdata speed_scale_ratio
// Each report runs a 4-bit-per-cycle divide by 15625 and a one-step-per-cycle
// CORDIC.
// Reset (rst_n low, synchronous) clears pose, heading and arrival history and
// sets the ratio to 1.0.
// A finished word waits in the output register; the next report is taken meanwhile,
// and its result stalls only until that word is taken.
`default_nettype none
module planar_odometry_integrator_core
  import poi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // arrival_time_us[31:0], forward_speed[63:32], yaw_rate[95:64], report_stamp[158:96]
  input  wire [IN_W-1:0]      in_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // stamp_out[62:0], position_x[110:63], position_y[158:111], heading[190:159],
  // quat_z[206:191], quat_w[222:207], scaled_speed[254:223], yaw_rate_out[286:255]
  output logic [OUT_W-1:0]    out_tdata,
  input  wire                 cfg_tvalid,
  output logic                cfg_tready,
  // speed_scale_ratio[23:0]
  input  wire [RATIO_W-1:0]   cfg_tdata
);

  poi_cmd_t  cmd;
  poi_stat_t stat;

  assign cfg_tready = 1'b1;

  poi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  poi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tdata  (cfg_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: hdl/poi_ctrl.sv
`default_nettype none
module poi_ctrl
  import poi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  poi_stat_t  stat,
  output poi_cmd_t   cmd
);

  localparam int ROT_N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  poi_state_t state_r, state_nxt;
  poi_sel_t   sel_r, sel_nxt;
  logic       half_r, half_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    half_nxt  = half_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = sel_r;
    cmd.half  = half_r;
    cmd.idx   = cnt_r[4:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          sel_nxt   = SEL_YAW;
          half_nxt  = 1'b0;
          state_nxt = ST_MDT;
        end
      end
      ST_MDT: begin
        cmd.mul_dt = 1'b1;
        state_nxt  = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MHI;
      end
      ST_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        unique case (sel_r)
          SEL_YAW: begin
            half_nxt  = 1'b0;
            state_nxt = ST_CLOAD;
          end
          SEL_X: begin
            sel_nxt   = SEL_Y;
            state_nxt = ST_MDT;
          end
          SEL_Y: begin
            half_nxt  = 1'b1;
            state_nxt = ST_CLOAD;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_CLOAD: begin
        cmd.cor_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.cor_step = 1'b1;
        if (cnt_r == CNT_W'(ROT_N - 1)) begin
          state_nxt = ST_CDONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CDONE: begin
        cmd.cor_done = 1'b1;
        if (half_r) begin
          state_nxt = ST_OUT;
        end else begin
          sel_nxt   = SEL_X;
          state_nxt = ST_MDT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_YAW;
      half_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      half_r  <= half_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/poi_dp.sv
`default_nettype none
module poi_dp
  import poi_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  poi_cmd_t           cmd,
  output poi_stat_t          stat,
  input  wire [IN_W-1:0]     in_tdata,
  input  wire                cfg_tvalid,
  input  wire [RATIO_W-1:0]  cfg_tdata,
  input  wire                out_tready,
  output logic               out_tvalid,
  output logic [OUT_W-1:0]   out_tdata
);

  function automatic logic [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] s;
    logic signed [17:0] r;
    s = 33'(v) + 33'sd16384;
    r = 18'(s >>> 15);
    if (r > 18'sd32767) r = 18'sd32767;
    else if (r < -18'sd32767) r = -18'sd32767;
    return r[15:0];
  endfunction

  logic [31:0] last_r, dt_r, w_r, v_r, yaw_r;
  logic        first_r;
  logic [62:0] stamp_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [POS_W-1:0] px_r, py_r;
  logic signed [56:0] sprod_r;
  logic [63:0] t_r, plo_r, phi_r;
  logic [DVD_W-1:0] dvd_r;
  logic [13:0] rem_r;
  logic [POS_W-1:0] q_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic        flip_r;
  logic signed [31:0] co_r, si_r;
  logic [15:0] qz_r, qw_r;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [31:0] w_mag, v_mag, co_mag, si_mag, kmul, mul_a, mul_b;
  logic [63:0] mul_p;
  logic [95:0] h96, n96;
  logic [DVD_W-1:0] dvd_ld, dvd_nxt;
  logic [13:0] rem_nxt;
  logic [3:0]  qb;
  logic [14:0] t15;
  logic [31:0] cor_ang;
  logic signed [33:0] zs, z0, sx, sy, atn, xc, yc;
  logic        flip0;
  logic [POS_W-1:0] dpos;
  logic        neg_pos;
  logic [31:0] dyaw;
  logic signed [40:0] sp_sh;
  logic [31:0] sp_sat;

  assign w_mag  = w_r[31] ? (~w_r + 32'd1) : w_r;
  assign v_mag  = v_r[31] ? (~v_r + 32'd1) : v_r;
  assign co_mag = co_r[31] ? 32'(-co_r) : 32'(co_r);
  assign si_mag = si_r[31] ? 32'(-si_r) : 32'(si_r);

  always_comb begin
    unique case (cmd.sel)
      SEL_YAW: kmul = TURN_PER_RAD;
      SEL_X:   kmul = co_mag;
      SEL_Y:   kmul = si_mag;
      default: kmul = '0;
    endcase
    if (cmd.mul_dt) begin
      mul_a = (cmd.sel == SEL_YAW) ? w_mag : v_mag;
      mul_b = dt_r;
    end else begin
      mul_a = cmd.mul_hi ? t_r[63:32] : t_r[31:0];
      mul_b = kmul;
    end
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign h96    = (cmd.sel == SEL_YAW) ? HALF_YAW : HALF_POS;
  assign n96    = {32'd0, plo_r} + {phi_r, 32'd0} + h96;
  assign dvd_ld = (cmd.sel == SEL_YAW) ? n96[93:22] : {4'd0, n96[95:28]};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    qb      = '0;
    t15     = '0;
    for (int k = 0; k < 4; k++) begin
      t15     = {rem_nxt, dvd_nxt[DVD_W-1]};
      dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
      if (t15 >= {1'b0, DIV_K}) begin
        rem_nxt    = 14'(t15 - {1'b0, DIV_K});
        qb[3 - k]  = 1'b1;
      end else begin
        rem_nxt = t15[13:0];
      end
    end
  end

  assign dyaw    = w_r[31] ? (32'd0 - q_r[31:0]) : q_r[31:0];
  assign neg_pos = v_r[31] ^ ((cmd.sel == SEL_X) ? co_r[31] : si_r[31]);
  assign dpos    = neg_pos ? ({POS_W{1'b0}} - q_r) : q_r;

  assign cor_ang = cmd.half ? {yaw_r[31], yaw_r[31:1]} : yaw_r;
  always_comb begin
    zs    = {{2{cor_ang[31]}}, cor_ang};
    flip0 = (zs > Q30_ONE) || (zs < -Q30_ONE);
    if (!flip0) z0 = zs;
    else if (zs > 34'sd0) z0 = zs - HALF_TURN;
    else z0 = zs + HALF_TURN;
  end

  assign sx  = cx_r >>> cmd.idx;
  assign sy  = cy_r >>> cmd.idx;
  assign atn = $signed({4'd0, atan_lut(cmd.idx)});

  always_comb begin
    if (cx_r > Q30_ONE) xc = Q30_ONE;
    else if (cx_r < -Q30_ONE) xc = -Q30_ONE;
    else xc = cx_r;
    if (cy_r > Q30_ONE) yc = Q30_ONE;
    else if (cy_r < -Q30_ONE) yc = -Q30_ONE;
    else yc = cy_r;
    if (flip_r) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_comb begin
    sp_sh = 41'((sprod_r + 57'sd32768) >>> 16);
    if (sp_sh > 41'sd2147483647) sp_sat = 32'h7FFF_FFFF;
    else if (sp_sh < -41'sd2147483648) sp_sat = 32'h8000_0000;
    else sp_sat = sp_sh[31:0];
  end

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      first_r     <= 1'b1;
      yaw_r       <= '0;
      px_r        <= '0;
      py_r        <= '0;
      ratio_r     <= RATIO_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_tvalid) ratio_r <= cfg_tdata;
      if (cmd.load) begin
        dt_r    <= first_r ? 32'd0 : (in_tdata[31:0] - last_r);
        last_r  <= in_tdata[31:0];
        first_r <= 1'b0;
      end
      if (cmd.upd) begin
        unique case (cmd.sel)
          SEL_YAW: yaw_r <= yaw_r + dyaw;
          SEL_X:   px_r  <= px_r + dpos;
          SEL_Y:   py_r  <= py_r + dpos;
          default: yaw_r <= yaw_r;
        endcase
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r     <= in_tdata[63:32];
      w_r     <= in_tdata[95:64];
      stamp_r <= in_tdata[158:96];
    end
    if (cmd.mul_dt) begin
      t_r     <= mul_p;
      sprod_r <= 57'($signed(v_r)) * 57'($signed({1'b0, ratio_r}));
    end
    if (cmd.mul_lo) plo_r <= mul_p;
    if (cmd.mul_hi) phi_r <= mul_p;
    if (cmd.div_load) begin
      dvd_r <= dvd_ld;
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r   <= {q_r[POS_W-5:0], qb};
    end
    if (cmd.cor_load) begin
      cx_r   <= COR_X0;
      cy_r   <= '0;
      cz_r   <= z0;
      flip_r <= flip0;
    end
    if (cmd.cor_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - atn;
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + atn;
      end
    end
    if (cmd.cor_done) begin
      if (cmd.half) begin
        qz_r <= to_q15(32'(yc));
        qw_r <= to_q15(32'(xc));
      end else begin
        co_r <= 32'(xc);
        si_r <= 32'(yc);
      end
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, w_r, sp_sat, qw_r, qz_r, yaw_r, py_r, px_r, stamp_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
module testbench;
  import poi_pkg::*;

  localparam int ROT_STEPS = CORDIC_STEPS_DEF;
  localparam int REPORT_CYCLES = 3 * (4 + 18 + 1) + 2 * (CORDIC_STEPS_DEF + 2) + 2;
  localparam int STALL_LIMIT = 4000;
  localparam logic [31:0] RAD_TO_TURN = 32'd683565276;
  localparam longint Q30 = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] yaw_rate;
    logic signed [31:0] speed;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic [31:0]        heading;
    logic [47:0]        pos_y;
    logic [47:0]        pos_x;
    logic [62:0]        stamp;
  } pose_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_tvalid;
  logic               cfg_tready;
  logic [RATIO_W-1:0] cfg_tdata;

  planar_odometry_integrator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  // pose model
  logic [RATIO_W-1:0] ratio_m;
  logic [31:0]        last_arrival_m;
  bit                 first_m;
  logic [31:0]        yaw_m;
  logic [47:0]        x_m;
  logic [47:0]        y_m;

  pose_t  pending_poses[$];
  int     errors;
  int     reports_sent;
  int     poses_seen;
  int     out_stall;
  int     idle_cycles;
  bit     no_gaps;
  logic [31:0] arrival_now;
  logic [62:0] stamp_now;

  longint atan_q30[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = 1'b1;
      #10 clk = 1'b0;
    end
  end

  function automatic logic [63:0] round_div(logic [63:0] mag, logic [31:0] mult, int sh);
    logic [127:0] p;
    p = {64'd0, mag} * {96'd0, mult};
    p = p + (128'd15625 << (sh - 1));
    p = p >> sh;
    p = p / 128'd15625;
    return p[63:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [31:0] v);
    longint s;
    s = longint'(v);
    return (s < 0) ? 64'(-s) : 64'(s);
  endfunction

  function automatic logic [31:0] yaw_increment(logic signed [31:0] w, logic [31:0] dt);
    logic [63:0] d;
    d = round_div(magnitude(w) * {32'd0, dt}, RAD_TO_TURN, 22);
    if (w < 0) d = -d;
    return d[31:0];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
    longint z, x, y, nx;
    bit flip;
    z = longint'(signed'(ang));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > Q30 || z < -Q30) begin
      z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_q30[i];
      end
      x = nx;
    end
    if (x > Q30) x = Q30;
    if (x < -Q30) x = -Q30;
    if (y > Q30) y = Q30;
    if (y < -Q30) y = -Q30;
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  function automatic logic [47:0] travel(logic [63:0] vm, bit neg, longint c);
    logic [63:0] d;
    d = round_div(vm, (c < 0) ? 32'(-c) : 32'(c), 28);
    if (neg != (c < 0)) d = -d;
    return d[47:0];
  endfunction

  function automatic logic signed [15:0] to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return 16'(r);
  endfunction

  task automatic integrate_report(input logic [31:0] t, input logic signed [31:0] v,
                                  input logic signed [31:0] w, input logic [62:0] s,
                                  output pose_t p);
    logic [31:0] dt, half;
    logic [63:0] vm;
    longint co, si, hc, hs, sp;
    dt = first_m ? 32'd0 : t - last_arrival_m;
    last_arrival_m = t;
    first_m = 1'b0;
    yaw_m = yaw_m + yaw_increment(w, dt);
    rotate(yaw_m, co, si);
    vm = magnitude(v) * {32'd0, dt};
    x_m = x_m + travel(vm, v < 0, co);
    y_m = y_m + travel(vm, v < 0, si);
    half = {yaw_m[31], yaw_m[31:1]};
    rotate(half, hc, hs);
    sp = (longint'(v) * longint'({8'd0, ratio_m}) + 32768) >>> 16;
    if (sp > 64'sd2147483647) sp = 64'sd2147483647;
    if (sp < -64'sd2147483648) sp = -64'sd2147483648;
    p.stamp = s;
    p.pos_x = x_m;
    p.pos_y = y_m;
    p.heading = yaw_m;
    p.quat_z = to_q15(hs);
    p.quat_w = to_q15(hc);
    p.speed = 32'(sp);
    p.yaw_rate = w;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_report(input logic [31:0] t, input logic signed [31:0] v,
                             input logic signed [31:0] w, input logic [62:0] s);
    pose_t p;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, s, w, v, t};
    do @(posedge clk); while (!in_tready);
    integrate_report(t, v, w, s, p);
    pending_poses.push_back(p);
    reports_sent++;
    arrival_now = t;
    stamp_now = s;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (REPORT_CYCLES + 20) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] r);
    drain();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= r;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    ratio_m = r;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    pose_t e, g;
    int roll;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready))
        idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL planar_odometry_integrator_core");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        g = out_tdata[286:0];
        poses_seen++;
        if (pending_poses.size() == 0) begin
          errors++;
          $display("%0t unexpected word %h", $time, out_tdata);
        end else begin
          e = pending_poses.pop_front();
          check_field("stamp", e.stamp, g.stamp);
          check_field("position_x", e.pos_x, g.pos_x);
          check_field("position_y", e.pos_y, g.pos_y);
          check_field("heading", e.heading, g.heading);
          check_field("quat_z", e.quat_z, g.quat_z);
          check_field("quat_w", e.quat_w, g.quat_w);
          check_field("scaled_speed", e.speed, g.speed);
          check_field("yaw_rate", e.yaw_rate, g.yaw_rate);
        end
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) out_stall <= $urandom_range(20, 200);
        else if (roll < 25) out_stall <= $urandom_range(1, 3);
        else out_stall <= 0;
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_first_report();
    send_report(32'hDEAD_BEEF, 32'sh0001_0000, 32'sh0002_0000, 63'd0);
    send_report(32'hDEAD_BEEF + 32'd20000, 32'sh0001_0000, 32'sh0002_0000, 63'd1);
  endtask

  task automatic test_extremes();
    send_report(arrival_now + 32'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1);
    send_report(arrival_now + 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, '0);
    send_report(arrival_now + 32'h8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 63'h5555);
    send_report(arrival_now, 32'sh8000_0000, 32'sh7FFF_FFFF, {1'b1, 62'd0});
    send_report(arrival_now + 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 63'h2AAA_AAAA);
    send_report(arrival_now + 32'hFFFF_FFFF, 32'sh8000_0000, 32'sd0, 63'd7);
    send_report(32'hFFFF_FFFF, 32'sd0, 32'sd0, 63'd8);
    send_report(32'd5, -32'sd1, -32'sd1, 63'd9);
  endtask

  // land the heading exactly on half a turn, hold it there for one report, then turn away from it
  task automatic test_half_turn();
    logic signed [31:0] rest;
    longint west;
    logic signed [31:0] w;
    rest = 32'h8000_0000 - yaw_m;
    west = longint'(unsigned'(rest)) * 64'sd65536 / 64'sd683565276;
    send_report(arrival_now + 32'd1000000, 32'sh0002_0000, 32'(west), 63'd100);
    rest = 32'h8000_0000 - yaw_m;
    west = longint'(rest) * 64'sd65536000000 / 64'sd683565276;
    w = 32'(west - 200);
    for (int k = 0; k < 400; k++) begin
      if (yaw_increment(w, 32'd1) == 32'(rest)) break;
      w = w + 1;
    end
    send_report(arrival_now + 32'd1, 32'sh0001_0000, w, 63'd101);
    send_report(arrival_now + 32'd50000, 32'sh0003_0000, 32'sd0, 63'd102);
    send_report(arrival_now + 32'd50000, -32'sh0003_0000, 32'sh0000_8000, 63'd103);
  endtask

  task automatic test_random(input int count);
    logic [31:0] t;
    logic signed [31:0] v, w;
    logic [62:0] s;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      t = arrival_now + $urandom_range(1000, 100000);
      v = $signed($urandom_range(0, 1310720)) - 32'sd655360;
      w = $signed($urandom_range(0, 393216)) - 32'sd196608;
      s = stamp_now + $urandom_range(1, 100000);
      case ($urandom_range(0, 9))
        7: begin
          t = $urandom;
          v = $urandom;
          w = $urandom;
          s = 63'({$urandom, $urandom});
        end
        8: begin
          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          w = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        9: begin
          t = arrival_now + $urandom;
          v = $urandom;
        end
        default: ;
      endcase
      send_report(t, v, w, s);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_tvalid = 1'b0;
    cfg_tdata = '0;
    reports_sent = 0;
    no_gaps = 1'b0;
    arrival_now = 32'd0;
    stamp_now = 63'd0;
    ratio_m = RATIO_RST;
    last_arrival_m = 32'd0;
    first_m = 1'b1;
    yaw_m = 32'd0;
    x_m = 48'd0;
    y_m = 48'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_report();
    test_half_turn();
    test_extremes();
    test_random(380);
    write_ratio(24'd0);
    test_extremes();
    test_random(380);
    write_ratio(24'hFF_FFFF);
    test_extremes();
    test_random(380);
    write_ratio(24'($urandom));
    test_random(380);
    write_ratio(RATIO_RST);
    test_random(380);
    drain();

    $display("Covered %0d velocity reports, %0d pose words checked,", reports_sent,
             poses_seen);
    $display("ratio at zero, one, full scale and random; half-turn heading and extremes.");
    if (errors == 0) begin
      $display("PASS planar_odometry_integrator_core");
    end else begin
      $display("FAIL planar_odometry_integrator_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
